FILE: design/row_euclidean_norm_unit_assert.svh
// Assertion macros for the row Euclidean norm unit.
`ifndef ROW_EUCLIDEAN_NORM_UNIT_ASSERT_SVH
`define ROW_EUCLIDEAN_NORM_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define RNU_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define RNU_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: design/rnorm_pkg.sv
// Shared constants and controller/datapath interface types of the row norm unit.
package rnorm_pkg;

	// Payload widths
	localparam int DATA_BITS   = 16;
	localparam int SUM_BITS    = 40;
	localparam int NORM_BITS   = SUM_BITS / 2;
	localparam int M_DATA_BITS = ((NORM_BITS + 7) / 8) * 8;

	// Parameter defaults
	localparam int MAX_ELEMENTS_DEF  = 256;
	localparam int ELEMENT_WIDTH_DEF = 16;

	// Saturation value of the sum of squares
	localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic root_start;
		logic root_step;
		logic out_load;
	} rnorm_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic row_done;
		logic out_busy;
	} rnorm_stat_t;

endpackage

FILE: design/rnorm_accum.sv
// Square-and-accumulate datapath: input register, squarer stage and saturating sum.
module rnorm_accum #(
	parameter int MAX_ELEMENTS  = rnorm_pkg::MAX_ELEMENTS_DEF,
	parameter int ELEMENT_WIDTH = rnorm_pkg::ELEMENT_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rnorm_pkg::rnorm_cmd_t          cmd,
	input  logic [rnorm_pkg::DATA_BITS-1:0] element_value,
	input  logic                           last_element,
	output logic                           row_done,
	output logic [rnorm_pkg::SUM_BITS-1:0] row_sum,
	output logic                           row_sat
);

	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
	localparam int SQ_W  = 2 * ELEMENT_WIDTH;
	localparam int ADD_W = ((SQ_W > rnorm_pkg::SUM_BITS) ? SQ_W : rnorm_pkg::SUM_BITS) + 1;

	logic                           valid_s1;
	logic                           last_s1;
	logic [rnorm_pkg::DATA_BITS-1:0] elem_s1;
	logic                           valid_s2;
	logic                           last_s2;
	logic [SQ_W-1:0]                sq_s2;

	logic [rnorm_pkg::SUM_BITS-1:0] sum_q;
	logic [CNT_W-1:0]               count_q;
	logic                           sat_q;
	logic                           row_done_q;
	logic [rnorm_pkg::SUM_BITS-1:0] done_sum_q;
	logic                           done_sat_q;

	logic [ELEMENT_WIDTH-1:0]       elem_raw;
	logic [ELEMENT_WIDTH-1:0]       mag;
	logic [SQ_W-1:0]                sq_comb;
	logic [ADD_W-1:0]               add_full;
	logic [rnorm_pkg::SUM_BITS-1:0] sum_n;
	logic [CNT_W-1:0]               count_n;
	logic                           sat_n;

	// Take the element at its configured width: its low bits when it fits the field, zero-extended when wider
	if (ELEMENT_WIDTH <= rnorm_pkg::DATA_BITS) begin : g_narrow
		assign elem_raw = elem_s1[ELEMENT_WIDTH-1:0];
	end else begin : g_wide
		assign elem_raw = {{(ELEMENT_WIDTH - rnorm_pkg::DATA_BITS){1'b0}}, elem_s1};
	end

	// Magnitude and exact square
	assign mag     = elem_raw[ELEMENT_WIDTH-1] ? (~elem_raw + ELEMENT_WIDTH'(1)) : elem_raw;
	assign sq_comb = mag * mag;

	// Capture the input word and square it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			elem_s1 <= element_value;
			last_s1 <= last_element;
		end
		if (valid_s1) begin
			sq_s2   <= sq_comb;
			last_s2 <= last_s1;
		end
	end

	// Saturating update of the running sum and element count
	assign add_full = ADD_W'(sum_q) + ADD_W'(sq_s2);

	always_comb begin
		sum_n   = sum_q;
		count_n = count_q;
		sat_n   = sat_q;
		if (!sat_q) begin
			if (count_q >= CNT_W'(MAX_ELEMENTS)) begin
				sum_n = rnorm_pkg::SUM_MAX;
				sat_n = 1'b1;
			end else begin
				count_n = count_q + CNT_W'(1);
				if (add_full > ADD_W'(rnorm_pkg::SUM_MAX)) begin
					sum_n = rnorm_pkg::SUM_MAX;
					sat_n = 1'b1;
				end else begin
					sum_n = add_full[rnorm_pkg::SUM_BITS-1:0];
				end
			end
		end
	end

	// Advance the accumulator; hand off and clear at the end of a row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			count_q    <= '0;
			sat_q      <= 1'b0;
			row_done_q <= 1'b0;
		end else begin
			row_done_q <= valid_s2 & last_s2;
			if (valid_s2) begin
				if (last_s2) begin
					sum_q   <= '0;
					count_q <= '0;
					sat_q   <= 1'b0;
				end else begin
					sum_q   <= sum_n;
					count_q <= count_n;
					sat_q   <= sat_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && last_s2) begin
			done_sum_q <= sum_n;
			done_sat_q <= sat_n;
		end
	end

	assign row_done = row_done_q;
	assign row_sum  = done_sum_q;
	assign row_sat  = done_sat_q;

endmodule

FILE: design/rnorm_sqrt.sv
// Bit-serial floor square root, one root bit per step, with the output register.
module rnorm_sqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rnorm_pkg::rnorm_cmd_t             cmd,
	input  logic [rnorm_pkg::SUM_BITS-1:0]    row_sum,
	input  logic                              row_sat,
	input  logic                              m_tready,
	output logic                              out_busy,
	output logic                              m_tvalid,
	output logic [rnorm_pkg::NORM_BITS-1:0]   norm_value,
	output logic                              overflow
);

	localparam int REM_W = rnorm_pkg::NORM_BITS + 2;

	logic [rnorm_pkg::SUM_BITS-1:0]  x_q;
	logic [REM_W-1:0]                rem_q;
	logic [rnorm_pkg::NORM_BITS-1:0] root_q;
	logic                            sat_q;
	logic                            out_valid_q;
	logic [rnorm_pkg::NORM_BITS-1:0] norm_q;
	logic                            ovf_q;

	logic [REM_W-1:0]                rem_shift;
	logic [REM_W-1:0]                trial;
	logic                            fits;

	// Bring down the next two radicand bits and try the next root bit
	assign rem_shift = {rem_q[REM_W-3:0], x_q[rnorm_pkg::SUM_BITS-1 -: 2]};
	assign trial     = {root_q, 2'b01};
	assign fits      = rem_shift >= trial;

	always_ff @(posedge clk) begin
		if (cmd.root_start) begin
			x_q    <= row_sum;
			rem_q  <= '0;
			root_q <= '0;
			sat_q  <= row_sat;
		end else if (cmd.root_step) begin
			x_q    <= {x_q[rnorm_pkg::SUM_BITS-3:0], 2'b00};
			rem_q  <= fits ? (rem_shift - trial) : rem_shift;
			root_q <= {root_q[rnorm_pkg::NORM_BITS-2:0], fits};
		end
	end

	// Hold the result word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			norm_q <= root_q;
			ovf_q  <= sat_q;
		end
	end

	assign out_busy   = out_valid_q & ~m_tready;
	assign m_tvalid   = out_valid_q;
	assign norm_value = norm_q;
	assign overflow   = ovf_q;

endmodule

FILE: design/rnorm_ctrl.sv
// Controller: row intake, hand-off to the root unit, root step count and result load.
module rnorm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tlast,
	input  rnorm_pkg::rnorm_stat_t stat,
	output logic                  s_tready,
	output rnorm_pkg::rnorm_cmd_t cmd
);

	localparam logic [1:0] ST_ACCUM  = 2'd0;
	localparam logic [1:0] ST_DRAIN  = 2'd1;
	localparam logic [1:0] ST_ROOT   = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	localparam int STEP_W = $clog2(rnorm_pkg::NORM_BITS);

	logic [1:0]        state_q;
	logic [1:0]        state_n;
	logic [STEP_W-1:0] step_q;
	logic              last_step;

	assign last_step = step_q == STEP_W'(rnorm_pkg::NORM_BITS - 1);

	// Next state and commands
	always_comb begin
		state_n        = state_q;
		s_tready       = 1'b0;
		cmd.accept     = 1'b0;
		cmd.root_start = 1'b0;
		cmd.root_step  = 1'b0;
		cmd.out_load   = 1'b0;
		unique case (state_q)
			ST_ACCUM: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
				if (s_tvalid && s_tlast) begin
					state_n = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (stat.row_done) begin
					cmd.root_start = 1'b1;
					state_n        = ST_ROOT;
				end
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (last_step) begin
					state_n = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_n      = ST_ACCUM;
				end
			end
			default: begin
				state_n = ST_ACCUM;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
			step_q  <= '0;
		end else begin
			state_q <= state_n;
			if (cmd.root_start) begin
				step_q <= '0;
			end else if (cmd.root_step) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

endmodule

FILE: design/row_euclidean_norm_unit.sv
// Top level of the row Euclidean norm unit: controller, accumulator and root unit.
//
// Streams the signed elements of one row, one word per cycle, squares each and keeps a
// 40-bit saturating sum of squares; the word marked with s_tlast closes the row and the
// unit returns floor(sqrt(sum)) on m_tdata with the overflow flag on m_tuser. Inside a
// row an element is taken every cycle. After the last element s_tready stays low while
// the row passes the input, squarer and accumulator registers, is handed off, goes through
// the 20 steps of the bit-serial root unit (one root bit per cycle) and is loaded into the
// output register, plus any wait for m_tready on the previous result word. A row longer than
// MAX_ELEMENTS, or one whose sum passes 2^40 - 1, returns 1048575 with overflow set.
module row_euclidean_norm_unit #(
	parameter int MAX_ELEMENTS  = rnorm_pkg::MAX_ELEMENTS_DEF,
	parameter int ELEMENT_WIDTH = rnorm_pkg::ELEMENT_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rnorm_pkg::DATA_BITS-1:0]   s_tdata,  // [15:0] element_value
	input  logic                              s_tlast,  // last_element
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rnorm_pkg::M_DATA_BITS-1:0] m_tdata,  // [19:0] norm_value, rest zero
	output logic                              m_tuser   // overflow
);

`include "row_euclidean_norm_unit_assert.svh"

	rnorm_pkg::rnorm_cmd_t           cmd;
	rnorm_pkg::rnorm_stat_t          stat;
	logic                            row_done;
	logic                            out_busy;
	logic [rnorm_pkg::SUM_BITS-1:0]  row_sum;
	logic                            row_sat;
	logic [rnorm_pkg::NORM_BITS-1:0] norm_value;

	rnorm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.stat     (stat),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	rnorm_accum #(
		.MAX_ELEMENTS  (MAX_ELEMENTS),
		.ELEMENT_WIDTH (ELEMENT_WIDTH)
	) u_accum (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.element_value (s_tdata),
		.last_element  (s_tlast),
		.row_done      (row_done),
		.row_sum       (row_sum),
		.row_sat       (row_sat)
	);

	rnorm_sqrt u_sqrt (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.row_sum    (row_sum),
		.row_sat    (row_sat),
		.m_tready   (m_tready),
		.out_busy   (out_busy),
		.m_tvalid   (m_tvalid),
		.norm_value (norm_value),
		.overflow   (m_tuser)
	);

	// Gather the datapath status for the controller
	assign stat = '{row_done: row_done, out_busy: out_busy};

	// Pad the norm to whole bytes
	assign m_tdata = {{(rnorm_pkg::M_DATA_BITS - rnorm_pkg::NORM_BITS){1'b0}}, norm_value};

	// Input must be closed while a row is finishing
	`RNU_ASSERT_NXT(a_close_after_last, clk, arst_n, s_tvalid && s_tready && s_tlast, !s_tready, "input open after last element")
	`RNU_ASSERT_IMP(a_row_done_closed, clk, arst_n, stat.row_done, !s_tready, "row end seen while input open")
	`RNU_ASSERT_IMP(a_root_closed, clk, arst_n, cmd.root_step, !s_tready && !cmd.out_load, "root step overlaps intake or load")
	// A pending result word is never overwritten
	`RNU_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.out_load, !m_tvalid || m_tready, "result overwritten while pending")

endmodule

FILE: sim/row_euclidean_norm_unit_tb.sv
// Self-checking testbench of the row Euclidean norm unit.
`timescale 1ns / 100ps

module row_euclidean_norm_unit_tb;

	localparam int ROW_LIMIT   = rnorm_pkg::MAX_ELEMENTS_DEF;
	localparam int TARGET_WORDS = 1700;
	localparam int STALL_LIMIT = 2000;
	localparam int REPORT_MAX  = 10;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic [rnorm_pkg::NORM_BITS-1:0] norm;
		logic                            overflow;
	} row_norm_t;

	// Row norm predictor and store of the norms still owed by the unit
	class norm_scoreboard;
		row_norm_t       owed_norms[$];
		longint unsigned sum_of_squares;
		int unsigned     row_length;
		bit              row_saturated;
		int unsigned     failures;

		function new();
			sum_of_squares = 0;
			row_length     = 0;
			row_saturated  = 0;
			failures       = 0;
		endfunction

		function int unsigned pending();
			return owed_norms.size();
		endfunction

		// Floor square root, one result bit at a time from the top
		function logic [rnorm_pkg::NORM_BITS-1:0] floor_root(longint unsigned x);
			longint unsigned root;
			longint unsigned trial;
			root = 0;
			for (int b = rnorm_pkg::NORM_BITS - 1; b >= 0; b--) begin
				trial = root | (64'd1 << b);
				if (trial * trial <= x)
					root = trial;
			end
			return root[rnorm_pkg::NORM_BITS-1:0];
		endfunction

		// Update the running sum with one accepted element word
		function void note_element(logic [rnorm_pkg::DATA_BITS-1:0] raw, logic last);
			longint          signed_value;
			longint unsigned square;
			longint unsigned sum_max;
			row_norm_t       result;
			signed_value = longint'($signed(raw));
			square       = longint'(signed_value * signed_value);
			sum_max      = longint'(rnorm_pkg::SUM_MAX);
			if (row_saturated) begin
				// row already overflowed: hold
			end else if (row_length >= ROW_LIMIT) begin
				sum_of_squares = sum_max;
				row_saturated  = 1;
			end else begin
				row_length++;
				if (square > sum_max || sum_of_squares > sum_max - square) begin
					sum_of_squares = sum_max;
					row_saturated  = 1;
				end else begin
					sum_of_squares += square;
				end
			end
			if (last) begin
				result.norm     = floor_root(sum_of_squares);
				result.overflow = row_saturated;
				owed_norms.push_back(result);
				sum_of_squares = 0;
				row_length     = 0;
				row_saturated  = 0;
			end
		endfunction

		// Compare one result word with the oldest owed norm
		function void check_norm(logic [rnorm_pkg::M_DATA_BITS-1:0] data, logic flag);
			row_norm_t                         want;
			logic [rnorm_pkg::M_DATA_BITS-1:0] want_data;
			if (owed_norms.size() == 0) begin
				failures++;
				if (failures <= REPORT_MAX)
					$display("%0t: unexpected result word norm=%0d overflow=%0b",
						$realtime, data, flag);
				return;
			end
			want      = owed_norms.pop_front();
			want_data = {{(rnorm_pkg::M_DATA_BITS - rnorm_pkg::NORM_BITS){1'b0}}, want.norm};
			if (data !== want_data || flag !== want.overflow) begin
				failures++;
				if (failures <= REPORT_MAX)
					$display({"%0t: norm mismatch: expected norm=%0d overflow=%0b,",
						" got norm=%0d overflow=%0b"},
						$realtime, want_data, want.overflow, data, flag);
			end
		endfunction
	endclass

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              s_tvalid = 1'b0;
	logic                              s_tready;
	logic [rnorm_pkg::DATA_BITS-1:0]   s_tdata = '0;  // [15:0] element_value
	logic                              s_tlast = 1'b0; // last_element
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	logic [rnorm_pkg::M_DATA_BITS-1:0] m_tdata;   // [19:0] norm_value, rest zero
	logic                              m_tuser;   // overflow

	norm_scoreboard sb = new();
	bit             steady_flow = 0;
	int unsigned    quiet_cycles = 0;
	int unsigned    random_words = 0;

	row_euclidean_norm_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #6 clk = ~clk;

	// Stall the result side at random unless the flow is steady
	always @(posedge clk) begin
		m_tready <= steady_flow || ($urandom_range(99) >= 34);
	end

	// Watch both handshakes and count cycles with no word moving
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			sb.note_element(s_tdata, s_tlast);
		if (m_tvalid && m_tready)
			sb.check_norm(m_tdata, m_tuser);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	// End the run if the unit hangs
	initial begin
		while (quiet_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("[row_euclidean_norm_unit] ERROR");
		$finish;
	end

	// Offer one element word, with random idle cycles ahead of it
	task automatic send_word(input logic [rnorm_pkg::DATA_BITS-1:0] value, input logic last);
		while (!steady_flow && $urandom_range(99) < 34) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Drop valid and hold until every owed norm has come back
	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Random element, biased toward the extremes
	function automatic logic [rnorm_pkg::DATA_BITS-1:0] pick_element();
		case ($urandom_range(15))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'h0000;
			3:       return 16'hFFFF;
			default: return rnorm_pkg::DATA_BITS'($urandom());
		endcase
	endfunction

	// Random row length, mostly short, rarely around the row limit
	function automatic int unsigned pick_length();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 1)
			return $urandom_range(ROW_LIMIT - 6, ROW_LIMIT + 14);
		else if (r < 10)
			return $urandom_range(9, 40);
		else
			return $urandom_range(1, 8);
	endfunction

	task automatic send_row(input int unsigned length);
		for (int unsigned i = 0; i < length; i++) begin
			send_word(pick_element(), i == length - 1);
			random_words++;
			// run a steady stretch with no idling on either side
			steady_flow = (random_words >= 600 && random_words < 900);
		end
	endtask

	initial begin
		int unsigned length;
		bit          drained_mid;
		drained_mid = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single-element rows at the extremes
		send_word(16'h0000, 1'b1);
		send_word(16'h7FFF, 1'b1);
		send_word(16'h8000, 1'b1);
		send_word(16'hFFFF, 1'b1);
		// Short rows with known norms
		send_word(16'h0001, 1'b0);
		send_word(16'h0001, 1'b0);
		send_word(16'h0001, 1'b0);
		send_word(16'h0001, 1'b1);
		send_word(16'h7FFF, 1'b0);
		send_word(16'h8000, 1'b0);
		send_word(16'h7FFF, 1'b0);
		send_word(16'h8000, 1'b1);
		send_word(16'h0100, 1'b0);
		send_word(16'h0100, 1'b0);
		send_word(16'h0100, 1'b1);
		send_word(16'h5555, 1'b0);
		send_word(16'hAAAA, 1'b1);
		send_word(16'h0003, 1'b0);
		send_word(16'h0004, 1'b1);
		hold_until_drained();

		// Rows at the limit, one past it and well past it
		send_row(ROW_LIMIT);
		send_row(ROW_LIMIT + 1);
		send_row(ROW_LIMIT + 5);

		// Random rows
		while (random_words < TARGET_WORDS) begin
			length = pick_length();
			send_row(length);
			if (!drained_mid && random_words >= 1100) begin
				drained_mid = 1;
				hold_until_drained();
			end
		end
		steady_flow = 0;
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (sb.failures == 0 && sb.pending() == 0)
			$display("[row_euclidean_norm_unit] OK");
		else
			$display("[row_euclidean_norm_unit] ERROR");
		$finish;
	end

endmodule

FILE: files.f
+incdir+design
design/rnorm_pkg.sv
design/rnorm_accum.sv
design/rnorm_sqrt.sv
design/rnorm_ctrl.sv
design/row_euclidean_norm_unit.sv
sim/row_euclidean_norm_unit_tb.sv
